>>> rtl/flba_pkg.sv
// Shared types and constants for the fixed-size block allocator.
`default_nettype none
package flba_pkg;

   localparam int INDEX_W  = 10;
   localparam int SIZE_W   = 4;
   localparam int COUNT_W  = 11;

   localparam logic ACTION_ALLOC = 1'b0;
   localparam logic ACTION_FREE  = 1'b1;

   typedef enum logic [1:0] {
      STATUS_OK    = 2'd0,
      STATUS_EMPTY = 2'd1,
      STATUS_SIZE  = 2'd2,
      STATUS_FULL  = 2'd3
   } status_type;

   // Outcome of one request, carried from the control unit into the read stage.
   typedef struct packed {
      status_type               status;
      logic                     grant;
      logic                     from_ram;
      logic [INDEX_W-1:0]       fallback_index;
      logic [COUNT_W-1:0]       free_blocks;
   } result_type;

endpackage
`default_nettype wire

>>> rtl/flba_ram.sv
// Generic single-port synchronous RAM with registered read.
`default_nettype none
module flba_ram #(
   parameter int WIDTH = 10,
   parameter int DEPTH = 1024
) (
   input  wire logic                     clock,
   input  wire logic                     en,
   input  wire logic                     we,
   input  wire logic [$clog2(DEPTH)-1:0] addr,
   input  wire logic [WIDTH-1:0]         wdata,
   output logic      [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         if (we) begin
            mem[addr] <= wdata;
         end else begin
            rdata_ff <= mem[addr];
         end
      end
   end

   assign rdata = rdata_ff;

endmodule
`default_nettype wire

>>> rtl/flba_ctrl.sv
// Pointer, occupancy and fill-count control for the free-list ring.
`default_nettype none
module flba_ctrl
   import flba_pkg::*;
#(
   parameter int POOL_BLOCKS = 1024,
   parameter int PW = $clog2(POOL_BLOCKS),
   parameter int CW = $clog2(POOL_BLOCKS + 1)
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               accept,
   input  wire logic               action,
   input  wire logic [SIZE_W-1:0]  request_size,
   input  wire logic [INDEX_W-1:0] block_index,
   output logic                    ram_en,
   output logic                    ram_we,
   output logic [PW-1:0]           ram_addr,
   output logic [INDEX_W-1:0]      ram_wdata,
   output result_type              result
);

   logic [PW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [PW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [CW-1:0] occ_ff, occ_in;
   // entries below fill_ff have been written since reset; the rest read as their own index
   logic [CW-1:0] fill_ff, fill_in;

   logic size_err, is_empty, is_full, alloc_ok, free_ok;
   logic [PW+INDEX_W-1:0] rd_ext;
   logic [CW+COUNT_W-1:0] occ_ext;

   assign size_err = request_size > SIZE_W'(1);
   assign is_empty = occ_ff == '0;
   assign is_full  = occ_ff == CW'(POOL_BLOCKS);
   assign alloc_ok = !size_err && (action == ACTION_ALLOC) && !is_empty;
   assign free_ok  = !size_err && (action == ACTION_FREE) && !is_full;

   assign rd_ext  = {{INDEX_W{1'b0}}, rd_ptr_ff};
   assign occ_ext = {{COUNT_W{1'b0}}, occ_in};

   always_comb begin
      rd_ptr_in = rd_ptr_ff;
      wr_ptr_in = wr_ptr_ff;
      occ_in    = occ_ff;
      fill_in   = fill_ff;
      if (accept && alloc_ok) begin
         rd_ptr_in = (rd_ptr_ff == PW'(POOL_BLOCKS - 1)) ? '0 : rd_ptr_ff + PW'(1);
         occ_in    = occ_ff - CW'(1);
      end
      if (accept && free_ok) begin
         wr_ptr_in = (wr_ptr_ff == PW'(POOL_BLOCKS - 1)) ? '0 : wr_ptr_ff + PW'(1);
         occ_in    = occ_ff + CW'(1);
         if (fill_ff != CW'(POOL_BLOCKS)) begin
            fill_in = fill_ff + CW'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rd_ptr_ff <= '0;
         wr_ptr_ff <= '0;
         occ_ff    <= CW'(POOL_BLOCKS);
         fill_ff   <= '0;
      end else begin
         rd_ptr_ff <= rd_ptr_in;
         wr_ptr_ff <= wr_ptr_in;
         occ_ff    <= occ_in;
         fill_ff   <= fill_in;
      end
   end

   always_comb begin
      if (size_err) begin
         result.status = STATUS_SIZE;
      end else if (action == ACTION_ALLOC) begin
         result.status = is_empty ? STATUS_EMPTY : STATUS_OK;
      end else begin
         result.status = is_full ? STATUS_FULL : STATUS_OK;
      end
      result.grant          = alloc_ok;
      result.from_ram       = CW'(rd_ptr_ff) < fill_ff;
      result.fallback_index = rd_ext[INDEX_W-1:0];
      result.free_blocks    = occ_ext[COUNT_W-1:0];
   end

   assign ram_en    = accept && (alloc_ok || free_ok);
   assign ram_we    = free_ok;
   assign ram_addr  = free_ok ? wr_ptr_ff : rd_ptr_ff;
   assign ram_wdata = block_index;

endmodule
`default_nettype wire

>>> rtl/fifo_free_list_block_allocator.sv
// Pipeline: a request transfer passes the ring read, then the output reg, before its response shows.
// Throughput: one request per cycle unless rsp_ready stalls the pipeline; allocate reads and
// free writes share one RAM port, and only one of them is needed per request.
// Reset: pointers and the fill count clear and the free count loads POOL_BLOCKS; the ring
// holds every block, served from a fill count until each entry is first rewritten, so no
// clearing pass runs. Responses stall only on rsp_ready.
`default_nettype none
module fifo_free_list_block_allocator
   import flba_pkg::*;
#(
   parameter int POOL_BLOCKS = 1024
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_valid,
   output logic                    req_ready,
   input  wire logic               req_action,
   input  wire logic [SIZE_W-1:0]  req_request_size,
   input  wire logic [INDEX_W-1:0] req_block_index,
   output logic                    rsp_valid,
   input  wire logic               rsp_ready,
   output logic [1:0]              rsp_status,
   output logic [INDEX_W-1:0]      rsp_granted_index,
   output logic [COUNT_W-1:0]      rsp_free_blocks
);

   localparam int PW = $clog2(POOL_BLOCKS);

   logic               accept;
   logic               ram_en, ram_we;
   logic [PW-1:0]      ram_addr;
   logic [INDEX_W-1:0] ram_wdata, ram_rdata;
   result_type         result;

   logic               s1_valid_ff, s1_valid_in;
   result_type         s1_result_ff;
   logic               s1_advance;

   logic               rsp_valid_ff, rsp_valid_in;
   status_type         rsp_status_ff;
   logic [INDEX_W-1:0] rsp_granted_ff, granted_in;
   logic [COUNT_W-1:0] rsp_free_ff;

   // s1 only moves when the output register frees up; the RAM read data holds meanwhile
   assign s1_advance = !rsp_valid_ff || rsp_ready;
   assign req_ready  = !s1_valid_ff || s1_advance;
   assign accept     = req_valid && req_ready;

   flba_ctrl #(
      .POOL_BLOCKS(POOL_BLOCKS)
   ) u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .accept      (accept),
      .action      (req_action),
      .request_size(req_request_size),
      .block_index (req_block_index),
      .ram_en      (ram_en),
      .ram_we      (ram_we),
      .ram_addr    (ram_addr),
      .ram_wdata   (ram_wdata),
      .result      (result)
   );

   flba_ram #(
      .WIDTH(INDEX_W),
      .DEPTH(POOL_BLOCKS)
   ) u_ram (
      .clock(clock),
      .en   (ram_en),
      .we   (ram_we),
      .addr (ram_addr),
      .wdata(ram_wdata),
      .rdata(ram_rdata)
   );

   always_comb begin
      s1_valid_in = s1_valid_ff;
      if (accept) begin
         s1_valid_in = 1'b1;
      end else if (s1_advance) begin
         s1_valid_in = 1'b0;
      end
      rsp_valid_in = rsp_valid_ff;
      if (s1_advance) begin
         rsp_valid_in = s1_valid_ff;
      end
      if (!s1_result_ff.grant) begin
         granted_in = '0;
      end else if (s1_result_ff.from_ram) begin
         granted_in = ram_rdata;
      end else begin
         granted_in = s1_result_ff.fallback_index;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_result_ff <= result;
      end
      if (s1_advance && s1_valid_ff) begin
         rsp_status_ff  <= s1_result_ff.status;
         rsp_granted_ff <= granted_in;
         rsp_free_ff    <= s1_result_ff.free_blocks;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_status        = rsp_status_ff;
   assign rsp_granted_index = rsp_granted_ff;
   assign rsp_free_blocks   = rsp_free_ff;

endmodule
`default_nettype wire

>>> rtl/flba_checker.sv
// Port-level checks for the block allocator, bound to the top level.
`default_nettype none
module flba_checker
   import flba_pkg::*;
#(
   parameter int POOL_BLOCKS = 1024
) (
   input wire logic               clock,
   input wire logic               reset,
   input wire logic               rsp_valid,
   input wire logic               rsp_ready,
   input wire logic [1:0]         rsp_status,
   input wire logic [INDEX_W-1:0] rsp_granted_index,
   input wire logic [COUNT_W-1:0] rsp_free_blocks
);

   localparam logic [COUNT_W-1:0] FULL_COUNT = COUNT_W'(POOL_BLOCKS);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_status)
         && $stable(rsp_granted_index) && $stable(rsp_free_blocks))
      else $error("response changed while stalled");

   a_no_grant_on_error: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status != STATUS_OK) |-> rsp_granted_index == '0)
      else $error("granted index nonzero on failed request");

   a_empty_count: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status == STATUS_EMPTY) |-> rsp_free_blocks == '0)
      else $error("empty status with free blocks left");

   a_full_count: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status == STATUS_FULL) |-> rsp_free_blocks == FULL_COUNT)
      else $error("full status with list not full");

endmodule

bind fifo_free_list_block_allocator flba_checker #(
   .POOL_BLOCKS(POOL_BLOCKS)
) u_flba_checker (
   .clock            (clock),
   .reset            (reset),
   .rsp_valid        (rsp_valid),
   .rsp_ready        (rsp_ready),
   .rsp_status       (rsp_status),
   .rsp_granted_index(rsp_granted_index),
   .rsp_free_blocks  (rsp_free_blocks)
);
`default_nettype wire
